@@ rtl/core/plb_pkg.sv @@
// Package for the pixel layer blend block: widths, blend mode and register codes,
// and the lane control struct. Used by plb_lane and pixel_layer_blend.
`default_nettype none
package plb_pkg;

  localparam int unsigned PixW     = 32;
  localparam int unsigned LaneW    = 8;
  localparam int unsigned NumLanes = PixW / LaneW;
  localparam int unsigned WeightW  = 7;
  localparam int unsigned TgtW     = 11;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned ModeW    = 4;

  typedef enum logic [ModeW-1:0] {
    MODE_ALPHA     = 4'd0,
    MODE_ADD       = 4'd1,
    MODE_SUB       = 4'd2,
    MODE_MUL       = 4'd3,
    MODE_SCREEN    = 4'd4,
    MODE_OVERLAY   = 4'd5,
    MODE_HARDLIGHT = 4'd6,
    MODE_LIGHTEN   = 4'd7,
    MODE_DARKEN    = 4'd8,
    MODE_DIFF      = 4'd9,
    MODE_DIFF5     = 4'd10,
    MODE_EXCL      = 4'd11
  } blend_mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BLEND_MODE = 2'd0,
    REG_OPA_EN     = 2'd1,
    REG_OPACITY    = 2'd2,
    REG_KEEP_ALPHA = 2'd3
  } cfg_reg_t;

  localparam logic [LaneW-1:0] OpacityReset = 8'hFF;

  typedef struct packed {
    logic en_a;
    logic en_b;
  } lane_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/core/plb_lane.sv @@
// One byte lane of the layer blend: product, target and mix stages.
// Depends on plb_pkg; the weight stages live in the top level.
`default_nettype none
module plb_lane (
  input  wire logic                     clk,
  input  wire plb_pkg::lane_ctrl_t      ctrl,
  input  wire logic [plb_pkg::ModeW-1:0]   mode,
  input  wire logic [plb_pkg::LaneW-1:0]   s_in,
  input  wire logic [plb_pkg::LaneW-1:0]   d_in,
  input  wire logic [plb_pkg::WeightW-1:0] w_a,
  input  wire logic [plb_pkg::WeightW-1:0] w_b,
  output logic      [plb_pkg::LaneW-1:0]   lane_out,
  output logic      [plb_pkg::LaneW-1:0]   d_out
);

  logic [plb_pkg::LaneW-1:0]     s_a_r, d_a_r, d_b_r;
  logic [2*plb_pkg::LaneW-1:0]   p_a_r;
  logic [plb_pkg::TgtW-1:0]      t_b_r, t_nxt;
  logic [plb_pkg::LaneW+plb_pkg::WeightW-1:0] sw_b_r, sw_nxt;

  logic [plb_pkg::LaneW:0]       sum;
  logic [plb_pkg::LaneW:0]       p7;
  logic [plb_pkg::LaneW-1:0]     p8;
  logic [plb_pkg::LaneW-1:0]     sel;
  logic [plb_pkg::TgtW-1:0]      t_hi;

  logic [plb_pkg::TgtW-1:0]      delta;
  logic signed [plb_pkg::TgtW+plb_pkg::LaneW-1:0] prod;
  logic [plb_pkg::LaneW-1:0]     mixed;
  logic [plb_pkg::LaneW-1:0]     sw_hi;
  logic [plb_pkg::LaneW-1:0]     diff5;

  always_ff @(posedge clk) begin
    if (ctrl.en_a) begin
      s_a_r <= s_in;
      d_a_r <= d_in;
      p_a_r <= s_in * d_in;
    end
    if (ctrl.en_b) begin
      t_b_r  <= t_nxt;
      d_b_r  <= d_a_r;
      sw_b_r <= sw_nxt;
    end
  end

  assign sum    = {1'b0, s_a_r} + {1'b0, d_a_r};
  assign p7     = p_a_r[15:7];
  assign p8     = p_a_r[15:8];
  assign sel    = (mode == plb_pkg::MODE_OVERLAY) ? d_a_r : s_a_r;
  assign t_hi   = {sum, 1'b0} + 11'(0) - 11'(p7) - 11'd255;
  assign sw_nxt = s_a_r * w_a;

  always_comb begin
    unique case (mode)
      plb_pkg::MODE_ALPHA:  t_nxt = 11'(s_a_r);
      plb_pkg::MODE_ADD:    t_nxt = (sum > 9'd255) ? 11'd255 : 11'(sum);
      plb_pkg::MODE_SUB:    t_nxt = (sum > 9'd255) ? 11'(sum - 9'd255) : 11'd0;
      plb_pkg::MODE_MUL:    t_nxt = 11'(p8);
      plb_pkg::MODE_SCREEN: t_nxt = 11'(sum) - 11'(p8);
      plb_pkg::MODE_OVERLAY, plb_pkg::MODE_HARDLIGHT: begin
        if (sel < 8'd128) begin
          t_nxt = 11'(p7);
        end else if (!t_hi[10] && (t_hi > 11'd255)) begin
          t_nxt = 11'd255;
        end else begin
          t_nxt = t_hi;
        end
      end
      plb_pkg::MODE_LIGHTEN: t_nxt = 11'((s_a_r > d_a_r) ? s_a_r : d_a_r);
      plb_pkg::MODE_DARKEN:  t_nxt = 11'((s_a_r < d_a_r) ? s_a_r : d_a_r);
      plb_pkg::MODE_DIFF:
        t_nxt = 11'((s_a_r > d_a_r) ? (s_a_r - d_a_r) : (d_a_r - s_a_r));
      plb_pkg::MODE_EXCL:    t_nxt = 11'(sum) - 11'(p7);
      default:               t_nxt = 11'(d_a_r);
    endcase
  end

  assign delta = t_b_r - 11'(d_b_r);
  assign prod  = $signed(delta) * $signed({1'b0, w_b});
  assign mixed = d_b_r + prod[14:7];
  assign sw_hi = sw_b_r[14:7];
  assign diff5 = (sw_hi > d_b_r) ? (sw_hi - d_b_r) : (d_b_r - sw_hi);

  always_comb begin
    if (mode == plb_pkg::MODE_DIFF5) begin
      lane_out = diff5;
    end else if (mode > plb_pkg::MODE_EXCL) begin
      lane_out = d_b_r;
    end else begin
      lane_out = mixed;
    end
  end

  assign d_out = d_b_r;

endmodule
`default_nettype wire

@@ rtl/core/pixel_layer_blend.sv @@
// Pixel layer blend top level: configuration registers, weight stages,
// four byte lanes and the merging output register. Depends on plb_pkg and plb_lane.
//
// Usage: a request on the in_ channel carries a destination and a source
// ARGB8888 pixel plus a span-end flag. Each request gives exactly one result
// on the out_ channel, in order, with the flag copied to out_last_out.
// The pipeline has three register stages: weight and lane products, the blend
// target, and the merged output register, which drives out_valid. One request is
// taken every cycle while results are being taken. The stage depth is set by
// the two multiplications in each lane (source times destination, then the
// signed difference times the weight), each followed by a register.
// When the receiver holds out_ready low, the stages in front of the output
// keep filling, so up to two more requests are accepted before in_ready falls.
// The cfg_ channel writes the four configuration registers and is always ready;
// the user must write it only while no request is in flight (not enforced here).
// Reset (rst_n low, synchronous) empties the pipeline and restores the
// registers: alpha mode, opacity off, opacity 255, alpha lane blended.
`default_nettype none
module pixel_layer_blend (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [plb_pkg::PixW-1:0]      in_dest_pixel,
  input  wire logic [plb_pkg::PixW-1:0]      in_src_pixel,
  input  wire logic                          in_last_pixel,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [plb_pkg::PixW-1:0]      out_result_pixel,
  output logic                               out_last_out,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [plb_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [plb_pkg::CfgDataW-1:0]  cfg_data
);

  localparam int unsigned NL = plb_pkg::NumLanes;
  localparam int unsigned LW = plb_pkg::LaneW;

  logic [plb_pkg::ModeW-1:0] mode_r;
  logic                      opa_en_r;
  logic [LW-1:0]             opacity_r;
  logic                      keep_alpha_r;

  logic v_a_r, v_b_r, out_valid_r;
  logic ready_a, ready_b, ready_c;
  plb_pkg::lane_ctrl_t ctrl;

  logic [plb_pkg::WeightW-1:0] w_raw, w_nxt, w_a_r, w_b_r;
  logic [plb_pkg::WeightW+LW-1:0] w_prod;
  logic last_a_r, last_b_r, last_out_r;
  logic [plb_pkg::PixW-1:0] result_r, result_nxt;

  logic [LW-1:0] lane_res [NL];
  logic [LW-1:0] lane_d   [NL];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= plb_pkg::MODE_ALPHA;
      opa_en_r     <= 1'b0;
      opacity_r    <= plb_pkg::OpacityReset;
      keep_alpha_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        plb_pkg::REG_BLEND_MODE: mode_r       <= cfg_data[plb_pkg::ModeW-1:0];
        plb_pkg::REG_OPA_EN:     opa_en_r     <= cfg_data[0];
        plb_pkg::REG_OPACITY:    opacity_r    <= cfg_data;
        plb_pkg::REG_KEEP_ALPHA: keep_alpha_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign ready_c  = !out_valid_r || out_ready;
  assign ready_b  = !v_b_r || ready_c;
  assign ready_a  = !v_a_r || ready_b;
  assign in_ready = ready_a;

  assign ctrl.en_a = in_valid && ready_a;
  assign ctrl.en_b = v_a_r && ready_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r       <= 1'b0;
      v_b_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ready_a) begin
        v_a_r <= in_valid;
      end
      if (ready_b) begin
        v_b_r <= v_a_r;
      end
      if (ready_c) begin
        out_valid_r <= v_b_r;
      end
    end
  end

  assign w_raw  = in_src_pixel[plb_pkg::PixW-1 -: plb_pkg::WeightW];
  assign w_prod = w_raw * opacity_r;
  assign w_nxt  = opa_en_r ? w_prod[plb_pkg::WeightW+LW-1 -: plb_pkg::WeightW] : w_raw;

  always_ff @(posedge clk) begin
    if (ctrl.en_a) begin
      w_a_r    <= w_nxt;
      last_a_r <= in_last_pixel;
    end
    if (ctrl.en_b) begin
      w_b_r    <= w_a_r;
      last_b_r <= last_a_r;
    end
    if (v_b_r && ready_c) begin
      result_r   <= result_nxt;
      last_out_r <= last_b_r;
    end
  end

  for (genvar i = 0; i < NL; i++) begin : g_lane
    plb_lane u_lane (
      .clk      (clk),
      .ctrl     (ctrl),
      .mode     (mode_r),
      .s_in     (in_src_pixel[i*LW +: LW]),
      .d_in     (in_dest_pixel[i*LW +: LW]),
      .w_a      (w_a_r),
      .w_b      (w_b_r),
      .lane_out (lane_res[i]),
      .d_out    (lane_d[i])
    );
  end

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      result_nxt[i*LW +: LW] = lane_res[i];
    end
    if (keep_alpha_r) begin
      result_nxt[(NL-1)*LW +: LW] = lane_d[NL-1];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_pixel = result_r;
  assign out_last_out     = last_out_r;

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v_a_r && v_b_r && out_valid_r))
    else $error("input stalled while a pipeline stage is empty");

  a_mid_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v_b_r && !ready_c) |=> v_b_r)
    else $error("target stage dropped a stalled request");

  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (v_b_r && ready_c) |=> out_valid_r)
    else $error("advancing request did not reach the output register");

endmodule
`default_nettype wire
